FILE: design/cpc_pkg.sv
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared types and constants of the cooling pump controller.
// ----------------------------------------------------------------------------
package cpc_pkg;

    // Pump mode codes
    localparam logic [1:0] MODE_FORCED_ON  = 2'd0;
    localparam logic [1:0] MODE_FORCED_OFF = 2'd1;
    localparam logic [1:0] MODE_AUTO       = 2'd2;

    // Register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_PUMP_MODE    = 3'd0;
    localparam logic [2:0] REG_OFF_TEMP     = 3'd1;
    localparam logic [2:0] REG_ON_TEMP      = 3'd2;
    localparam logic [2:0] REG_OVER_TEMP    = 3'd3;
    localparam logic [2:0] REG_MIN_IN_FLOW  = 3'd4;
    localparam logic [2:0] REG_CHECK_PERIOD = 3'd5;

    // Register reset values
    localparam logic [1:0]        RST_PUMP_MODE    = MODE_AUTO;
    localparam logic [7:0]        RST_OFF_TEMP     = 8'd0;
    localparam logic [7:0]        RST_ON_TEMP      = 8'd0;
    localparam logic signed [15:0] RST_OVER_TEMP   = 16'sh7FFF;
    localparam logic signed [15:0] RST_MIN_IN_FLOW = 16'sh0000;
    localparam logic [7:0]        RST_CHECK_PERIOD = 8'd100;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Input word: one control tick
    typedef struct packed {
        logic               message_valid;
        logic signed [15:0] temp_a;
        logic signed [15:0] temp_b;
        logic signed [15:0] inlet_flow;
        logic signed [15:0] outlet_flow;
    } t_in_word;

    // Output word: result of one tick
    typedef struct packed {
        logic               pump_drive;
        logic signed [15:0] process_temp;
        logic               timeout_alarm;
        logic               dry_alarm;
        logic               leak_alarm;
        logic               overheat_alarm;
    } t_out_word;

    // Configuration seen by the control core
    typedef struct packed {
        logic [1:0]         pump_mode;
        logic [7:0]         off_temp;
        logic [7:0]         on_temp;
        logic signed [15:0] over_temp;
        logic signed [15:0] min_inlet_flow;
        logic [7:0]         flow_check_period;
    } t_cfg;

endpackage

FILE: design/cpc_regs.sv
// ----------------------------------------------------------------------------
// cpc_regs
// APB-style configuration register file; writes complete in the access phase.
// ----------------------------------------------------------------------------
module cpc_regs
    import cpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    // Register writes; unmapped indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pump_mode         <= RST_PUMP_MODE;
            r_cfg.off_temp          <= RST_OFF_TEMP;
            r_cfg.on_temp           <= RST_ON_TEMP;
            r_cfg.over_temp         <= RST_OVER_TEMP;
            r_cfg.min_inlet_flow    <= RST_MIN_IN_FLOW;
            r_cfg.flow_check_period <= RST_CHECK_PERIOD;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PUMP_MODE:    r_cfg.pump_mode         <= pwdata[1:0];
                REG_OFF_TEMP:     r_cfg.off_temp          <= pwdata[7:0];
                REG_ON_TEMP:      r_cfg.on_temp           <= pwdata[7:0];
                REG_OVER_TEMP:    r_cfg.over_temp         <= $signed(pwdata[15:0]);
                REG_MIN_IN_FLOW:  r_cfg.min_inlet_flow    <= $signed(pwdata[15:0]);
                REG_CHECK_PERIOD: r_cfg.flow_check_period <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read mux, zero extended
    always_comb begin
        unique case (reg_idx)
            REG_PUMP_MODE:    prdata = {30'd0, r_cfg.pump_mode};
            REG_OFF_TEMP:     prdata = {24'd0, r_cfg.off_temp};
            REG_ON_TEMP:      prdata = {24'd0, r_cfg.on_temp};
            REG_OVER_TEMP:    prdata = {16'd0, r_cfg.over_temp};
            REG_MIN_IN_FLOW:  prdata = {16'd0, r_cfg.min_inlet_flow};
            REG_CHECK_PERIOD: prdata = {24'd0, r_cfg.flow_check_period};
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: design/cpc_core.sv
// ----------------------------------------------------------------------------
// cpc_core
// Tick pipeline: input register, control logic with state, result register.
// ----------------------------------------------------------------------------
module cpc_core
    import cpc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    // Pipeline registers
    logic      r_s1_valid;
    t_in_word  r_s1_word;
    logic      r_out_valid;
    t_out_word r_out_word;

    // Controller state
    logic               r_pump_on, n_pump_on;
    logic               r_stop_latch, n_stop_latch;
    logic               r_leak_latch, n_leak_latch;
    logic [7:0]         r_tick_count, n_tick_count;
    logic signed [15:0] r_held_t1, n_held_t1;
    logic signed [15:0] r_held_t2, n_held_t2;
    logic signed [15:0] r_held_fin, n_held_fin;
    logic signed [15:0] r_held_fout, n_held_fout;

    logic               s1_adv;
    logic               do_tick;
    logic               check_now;
    logic signed [15:0] proc_temp;
    logic signed [15:0] stop_s;
    logic signed [15:0] start_s;
    t_out_word          n_out_word;

    // Handshake: stage 1 moves on when the result register is free or drains
    assign s1_adv     = !r_out_valid || !i_out_stall;
    assign do_tick    = r_s1_valid && s1_adv;
    assign o_in_stall = r_s1_valid && !s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_s1_word <= i_in_word;
        end
    end

    // Tick logic
    always_comb begin
        n_held_t1   = r_s1_word.message_valid ? r_s1_word.temp_a      : r_held_t1;
        n_held_t2   = r_s1_word.message_valid ? r_s1_word.temp_b      : r_held_t2;
        n_held_fin  = r_s1_word.message_valid ? r_s1_word.inlet_flow  : r_held_fin;
        n_held_fout = r_s1_word.message_valid ? r_s1_word.outlet_flow : r_held_fout;

        proc_temp = (n_held_t1 > n_held_t2) ? n_held_t1 : n_held_t2;
        stop_s    = $signed({8'd0, i_cfg.off_temp});
        start_s   = $signed({8'd0, i_cfg.on_temp});

        // Periodic flow check, sees the pump state from before the tick
        check_now    = (r_tick_count >= i_cfg.flow_check_period);
        n_stop_latch = r_stop_latch;
        n_leak_latch = r_leak_latch;
        if (check_now) begin
            priority if (n_held_fin < i_cfg.min_inlet_flow) begin
                if (r_pump_on) n_stop_latch = 1'b1;
            end else if ((n_held_fin < 0 && n_held_fout > 0) ||
                         (n_held_fin > 0 && n_held_fout < 0)) begin
                n_leak_latch = 1'b1;
            end else begin
                n_stop_latch = 1'b0;
                n_leak_latch = 1'b0;
            end
        end
        n_tick_count = (check_now ? 8'd0 : r_tick_count) + 8'd1;

        // Pump decision; an unused mode code holds the pump
        n_pump_on = r_pump_on;
        priority if (i_cfg.pump_mode == MODE_FORCED_ON) begin
            n_pump_on = 1'b1;
        end else if (i_cfg.pump_mode == MODE_FORCED_OFF) begin
            n_pump_on = 1'b0;
        end else if (i_cfg.pump_mode == MODE_AUTO) begin
            priority if (n_stop_latch || n_leak_latch) begin
                n_pump_on = 1'b0;
            end else if (r_pump_on && proc_temp <= stop_s) begin
                n_pump_on = 1'b0;
            end else if (!r_pump_on && proc_temp >= start_s) begin
                n_pump_on = 1'b1;
            end else begin
                // inside the band the pump keeps its state
                n_pump_on = r_pump_on;
            end
        end else begin
            n_pump_on = r_pump_on;
        end

        n_out_word.pump_drive     = n_pump_on;
        n_out_word.process_temp   = proc_temp;
        n_out_word.timeout_alarm  = !r_s1_word.message_valid;
        n_out_word.dry_alarm      = n_stop_latch;
        n_out_word.leak_alarm     = n_leak_latch;
        n_out_word.overheat_alarm = (proc_temp >= i_cfg.over_temp);
    end

    // State update, one tick per accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pump_on    <= 1'b0;
            r_stop_latch <= 1'b0;
            r_leak_latch <= 1'b0;
            r_tick_count <= 8'd0;
            r_held_t1    <= '0;
            r_held_t2    <= '0;
            r_held_fin   <= '0;
            r_held_fout  <= '0;
        end else if (do_tick) begin
            r_pump_on    <= n_pump_on;
            r_stop_latch <= n_stop_latch;
            r_leak_latch <= n_leak_latch;
            r_tick_count <= n_tick_count;
            r_held_t1    <= n_held_t1;
            r_held_t2    <= n_held_t2;
            r_held_fin   <= n_held_fin;
            r_held_fout  <= n_held_fout;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_tick) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Assertions
    a_forced_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_tick && i_cfg.pump_mode == MODE_FORCED_ON |=> r_pump_on)
        else $error("forced-on mode left pump off");

    a_forced_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_tick && i_cfg.pump_mode == MODE_FORCED_OFF |=> !r_pump_on)
        else $error("forced-off mode left pump running");

    a_drive_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_tick |=> r_out_word.pump_drive == r_pump_on)
        else $error("reported pump drive differs from pump state");

    a_latch_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_tick && i_cfg.pump_mode == MODE_AUTO && (n_stop_latch || n_leak_latch)
        |=> !r_pump_on)
        else $error("pump running with a latch set in auto mode");

    a_hold_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid && $stable(r_tick_count))
        else $error("stalled tick lost or state advanced");

endmodule

FILE: design/cooling_pump_controller.sv
// ----------------------------------------------------------------------------
// cooling_pump_controller
// Hysteresis cooling pump controller, one control tick per input word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_word) carries one control
//   tick: message flag, two motor temperatures, inlet and outlet flow.
//   Output channel (o_out_valid / i_out_stall / o_out_word) returns one word
//   per tick: pump drive, process temperature and the four alarms.
//   Configuration goes through the APB-style port, register i at byte
//   address 4*i; pready is always high, writes take setup plus access.
//   A word accepted into the input register passes the tick logic into the
//   result register, which drives the output. Throughput: one word per cycle
//   while the receiver does not stall; the tick logic sets that figure.
//   When the receiver stalls, the result register holds its word and the
//   input register takes at most one more word; after that o_in_stall rises.
//   Reset (synchronous, active low) empties the pipeline, turns the pump off,
//   clears the latches, tick counter and held readings, and loads the
//   register defaults (automatic mode, period 100).
// ----------------------------------------------------------------------------
module cooling_pump_controller
    import cpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_word,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg cfg;

    // Configuration registers
    cpc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Tick pipeline
    cpc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the cooling pump controller: register access,
// directed ticks over hysteresis, flow checks and pump modes, then random
// ticks under several register settings with idling and a long output stall.
// ----------------------------------------------------------------------------
module testbench;
    import cpc_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [2:0] REG_SPARE   = 3'd6;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         HOLD_LEN    = 300;
    localparam int         PHASE_TICKS = 150;

    // DUT signals; the inputs driven by the bench are known from time zero
    logic                  i_clk       = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    t_in_word              in_word     = '0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    t_out_word             out_word;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Register mirror
    logic [1:0]         cfg_mode     = RST_PUMP_MODE;
    logic [7:0]         cfg_stop     = RST_OFF_TEMP;
    logic [7:0]         cfg_start    = RST_ON_TEMP;
    logic signed [15:0] cfg_over     = RST_OVER_TEMP;
    logic signed [15:0] cfg_min_flow = RST_MIN_IN_FLOW;
    logic [7:0]         cfg_period   = RST_CHECK_PERIOD;

    // Controller state mirror
    logic               pump_running = 1'b0;
    logic               dry_latched  = 1'b0;
    logic               leak_latched = 1'b0;
    logic [7:0]         ticks_since  = 8'd0;
    logic signed [15:0] held_one     = '0;
    logic signed [15:0] held_two     = '0;
    logic signed [15:0] held_inlet   = '0;
    logic signed [15:0] held_outlet  = '0;

    t_out_word pending_results[$];

    // Run control and statistics
    bit gaps_on       = 1'b1;
    bit stall_on      = 1'b1;
    int hold_requests = 0;
    int holds_done    = 0;
    int hold_left     = 0;
    int error_count   = 0;
    int cycle_count   = 0;
    int ticks_sent    = 0;
    int words_checked = 0;
    int settings_used = 0;
    int dry_seen      = 0;
    int leak_seen     = 0;
    int overheat_seen = 0;

    cooling_pump_controller i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Clock, 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report_mismatch(string what, int got, int want);
        error_count++;
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // Predict one tick: hold, process temp, flow check, pump update
    function automatic t_out_word advance_tick(t_in_word w);
        logic               was_on;
        logic signed [15:0] hottest;
        t_out_word          r;
        was_on = pump_running;
        if (w.message_valid) begin
            held_one    = w.temp_a;
            held_two    = w.temp_b;
            held_inlet  = w.inlet_flow;
            held_outlet = w.outlet_flow;
        end
        hottest = (held_one > held_two) ? held_one : held_two;

        if (ticks_since >= cfg_period) begin
            if (held_inlet < cfg_min_flow) begin
                if (was_on)
                    dry_latched = 1'b1;
            end else if ((held_inlet < 0 && held_outlet > 0) ||
                         (held_inlet > 0 && held_outlet < 0)) begin
                leak_latched = 1'b1;
            end else begin
                dry_latched  = 1'b0;
                leak_latched = 1'b0;
            end
            ticks_since = 8'd0;
        end

        case (cfg_mode)
            MODE_FORCED_ON:  pump_running = 1'b1;
            MODE_FORCED_OFF: pump_running = 1'b0;
            MODE_AUTO: begin
                if (dry_latched || leak_latched)
                    pump_running = 1'b0;
                else if (was_on && int'(hottest) <= int'(cfg_stop))
                    pump_running = 1'b0;
                else if (!was_on && int'(hottest) >= int'(cfg_start))
                    pump_running = 1'b1;
            end
            default: ;  // unused mode keeps the pump as it is
        endcase
        ticks_since = ticks_since + 8'd1;

        r.pump_drive     = pump_running;
        r.process_temp   = hottest;
        r.timeout_alarm  = !w.message_valid;
        r.dry_alarm      = dry_latched;
        r.leak_alarm     = leak_latched;
        r.overheat_alarm = (hottest >= cfg_over);
        return r;
    endfunction

    // Output side: check accepted words
    always @(posedge i_clk) begin
        t_out_word want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected output word, queue depth", 0, 0);
            end else begin
                want = pending_results.pop_front();
                words_checked++;
                dry_seen      += want.dry_alarm;
                leak_seen     += want.leak_alarm;
                overheat_seen += want.overheat_alarm;
                if (out_word.pump_drive !== want.pump_drive)
                    report_mismatch("pump_drive", out_word.pump_drive, want.pump_drive);
                if (out_word.process_temp !== want.process_temp)
                    report_mismatch("process_temp", out_word.process_temp,
                                    want.process_temp);
                if (out_word.timeout_alarm !== want.timeout_alarm)
                    report_mismatch("timeout_alarm", out_word.timeout_alarm,
                                    want.timeout_alarm);
                if (out_word.dry_alarm !== want.dry_alarm)
                    report_mismatch("dry_alarm", out_word.dry_alarm, want.dry_alarm);
                if (out_word.leak_alarm !== want.leak_alarm)
                    report_mismatch("leak_alarm", out_word.leak_alarm, want.leak_alarm);
                if (out_word.overheat_alarm !== want.overheat_alarm)
                    report_mismatch("overheat_alarm", out_word.overheat_alarm,
                                    want.overheat_alarm);
            end
        end
    end

    // Output stall: random idling, long hold counted in cycles on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (holds_done != hold_requests) begin
            holds_done++;
            hold_left = HOLD_LEN;
            out_stall <= 1'b1;
        end else begin
            out_stall <= stall_on && ($urandom_range(99) < 10);
        end
    end

    // Send one word, with occasional idle cycles ahead of it
    task automatic send_tick(t_in_word w);
        while (gaps_on && $urandom_range(99) < 10) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (in_stall);
        pending_results.push_back(advance_tick(w));
        ticks_sent++;
    endtask

    // Stop sending and wait for every expected word plus pipeline slack
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] reg_mask(logic [2:0] idx);
        case (idx)
            REG_PUMP_MODE:                                return 32'h3;
            REG_OFF_TEMP, REG_ON_TEMP, REG_CHECK_PERIOD:  return 32'hFF;
            default:                                      return 32'hFFFF;
        endcase
    endfunction

    function automatic logic [31:0] mirror_value(logic [2:0] idx);
        case (idx)
            REG_PUMP_MODE:    return 32'(cfg_mode);
            REG_OFF_TEMP:     return 32'(cfg_stop);
            REG_ON_TEMP:      return 32'(cfg_start);
            REG_OVER_TEMP:    return 32'(unsigned'(cfg_over));
            REG_MIN_IN_FLOW:  return 32'(unsigned'(cfg_min_flow));
            REG_CHECK_PERIOD: return 32'(cfg_period);
            default:          return 32'h0;
        endcase
    endfunction

    // APB write: setup then access, register takes it at the access edge
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_PUMP_MODE:    cfg_mode     = val[1:0];
            REG_OFF_TEMP:     cfg_stop     = val[7:0];
            REG_ON_TEMP:      cfg_start    = val[7:0];
            REG_OVER_TEMP:    cfg_over     = val[15:0];
            REG_MIN_IN_FLOW:  cfg_min_flow = val[15:0];
            REG_CHECK_PERIOD: cfg_period   = val[7:0];
            default: ;
        endcase
    endtask

    // APB read, data sampled at the access edge
    task automatic read_check(logic [2:0] idx);
        logic [31:0] got;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if ((got & reg_mask(idx)) !== mirror_value(idx))
            report_mismatch($sformatf("register %0d readback", idx),
                            got & reg_mask(idx), mirror_value(idx));
    endtask

    task automatic apply_settings(logic [1:0] mode, int stop_t, int start_t,
                                  int over_t, int min_flow, int period);
        write_reg(REG_PUMP_MODE,    32'(mode));
        write_reg(REG_OFF_TEMP,     32'(stop_t));
        write_reg(REG_ON_TEMP,      32'(start_t));
        write_reg(REG_OVER_TEMP,    32'(over_t));
        write_reg(REG_MIN_IN_FLOW,  32'(min_flow));
        write_reg(REG_CHECK_PERIOD, 32'(period));
        settings_used++;
    endtask

    function automatic t_in_word mk_tick(logic fresh, int t1, int t2, int fin, int fout);
        t_in_word w;
        w.message_valid = fresh;
        w.temp_a        = 16'(t1);
        w.temp_b        = 16'(t2);
        w.inlet_flow    = 16'(fin);
        w.outlet_flow   = 16'(fout);
        return w;
    endfunction

    // Temperatures mostly near the thresholds, sometimes anywhere
    function automatic int rand_temp();
        case ($urandom_range(9))
            0:       return int'($signed(16'($urandom)));
            1:       return int'($urandom_range(0, 100)) - 50;
            default: return int'($urandom_range(0, 280));
        endcase
    endfunction

    // Flows mostly small with both signs, some zero, some anywhere
    function automatic int rand_flow();
        case ($urandom_range(9))
            0, 1:    return int'($signed(16'($urandom)));
            2:       return 0;
            default: return int'($urandom_range(0, 80)) - 30;
        endcase
    endfunction

    function automatic t_in_word random_tick();
        return mk_tick($urandom_range(99) < 85, rand_temp(), rand_temp(),
                       rand_flow(), rand_flow());
    endfunction

    task automatic random_settings();
        logic [1:0] mode;
        int         pick;
        int         over_t;
        int         period;
        pick = $urandom_range(99);
        if (pick < 60)      mode = MODE_AUTO;
        else if (pick < 75) mode = MODE_FORCED_ON;
        else if (pick < 90) mode = MODE_FORCED_OFF;
        else                mode = MODE_UNUSED;
        over_t = ($urandom_range(3) == 0) ? int'($signed(16'($urandom)))
                                          : int'($urandom_range(0, 300));
        case ($urandom_range(5))
            0:       period = 255;
            1:       period = 100;
            default: period = $urandom_range(0, 12);
        endcase
        apply_settings(mode, $urandom_range(0, 200), $urandom_range(0, 255), over_t,
                       int'($urandom_range(0, 50)) - 20, period);
    endtask

    task automatic run_random(int count);
        repeat (count) send_tick(random_tick());
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_register_defaults();
        for (int i = REG_PUMP_MODE; i <= REG_CHECK_PERIOD; i++)
            read_check(3'(i));
    endtask

    task automatic test_register_access();
        for (int i = REG_PUMP_MODE; i <= REG_CHECK_PERIOD; i++) begin
            write_reg(3'(i), 32'hFFFF_FFFF);
            read_check(3'(i));
            write_reg(3'(i), 32'hA5A5_5A5A);
            read_check(3'(i));
        end
        // spare address must not disturb any register
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        for (int i = REG_PUMP_MODE; i <= REG_CHECK_PERIOD; i++)
            read_check(3'(i));
        settings_used++;
    endtask

    task automatic test_field_extremes();
        send_tick(mk_tick(1'b1, 32767, -32768, 32767, -32768));
        send_tick(mk_tick(1'b1, -32768, 32767, -32768, 32767));
        send_tick(mk_tick(1'b0, -1, -1, -1, -1));   // timeout, payload ignored
        send_tick(mk_tick(1'b1, -32768, -32768, 0, 0));
        settle();
    endtask

    task automatic test_hysteresis();
        apply_settings(MODE_AUTO, 20, 40, 50, -32768, 255);
        send_tick(mk_tick(1'b1, 30, 25, 10, 10));       // inside band, stays off
        send_tick(mk_tick(1'b1, 45, 0, 10, 10));        // start
        send_tick(mk_tick(1'b1, 30, 10, 10, 10));       // inside band, stays on
        send_tick(mk_tick(1'b1, 20, -5, 10, 10));       // at stop temp
        send_tick(mk_tick(1'b0, 99, 99, 99, 99));       // timeout keeps held temps
        send_tick(mk_tick(1'b1, 60, 70, 10, 10));       // start, overheat
        send_tick(mk_tick(1'b1, -32768, 50, 10, 10));   // exactly at overheat limit
        settle();
    endtask

    task automatic test_flow_check();
        // period 0: flow check on every tick
        apply_settings(MODE_AUTO, 20, 40, 32767, -10, 0);
        send_tick(mk_tick(1'b1, 50, 50, -20, -20));     // dry while running
        send_tick(mk_tick(1'b1, 50, 50, -20, -20));     // dry while stopped
        send_tick(mk_tick(1'b1, 50, 50, 15, 15));       // clean, restart
        send_tick(mk_tick(1'b1, 50, 50, -5, 7));        // leak, inlet negative
        send_tick(mk_tick(1'b1, 50, 50, 0, -5));        // zero inlet is clean
        send_tick(mk_tick(1'b1, 50, 50, 15, -3));       // leak, outlet negative
        send_tick(mk_tick(1'b0, 0, 0, 0, 0));           // timeout reuses held flows
        send_tick(mk_tick(1'b1, 50, 50, 1, 1));         // clean
        settle();
    endtask

    task automatic test_modes();
        // crossed thresholds
        apply_settings(MODE_AUTO, 200, 100, 32767, -32768, 255);
        send_tick(mk_tick(1'b1, 150, 0, 5, 5));         // running, below stop
        send_tick(mk_tick(1'b1, 150, 0, 5, 5));         // stopped, above start
        send_tick(mk_tick(1'b1, 250, 0, 5, 5));         // stays on
        settle();
        write_reg(REG_PUMP_MODE, 32'(MODE_FORCED_ON));
        send_tick(mk_tick(1'b1, -100, -100, 5, 5));
        settle();
        write_reg(REG_PUMP_MODE, 32'(MODE_FORCED_OFF));
        send_tick(mk_tick(1'b1, 300, 300, 5, 5));
        settle();
        write_reg(REG_PUMP_MODE, 32'(MODE_UNUSED));
        send_tick(mk_tick(1'b1, 300, 300, 5, 5));
        settle();
        settings_used += 3;
    endtask

    task automatic test_backpressure();
        random_settings();
        hold_requests++;
        run_random(PHASE_TICKS);
    endtask

    task automatic test_random_ticks();
        for (int phase = 0; phase < 9; phase++) begin
            case (phase)
                0:       apply_settings(MODE_AUTO, 255, 255, -32768, 32767, 255);
                1:       apply_settings(MODE_AUTO, 0, 0, 32767, -32768, 1);
                default: random_settings();
            endcase
            // one phase runs with no idling on either side
            gaps_on  = (phase != 3);
            stall_on = (phase != 3);
            run_random(PHASE_TICKS);
        end
        gaps_on  = 1'b1;
        stall_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_defaults();
        test_field_extremes();
        test_register_access();
        test_hysteresis();
        test_flow_check();
        test_modes();
        test_backpressure();
        test_random_ticks();

        settle();
        repeat (10) @(posedge i_clk);

        $display("Covered %0d ticks, %0d words checked, %0d register settings",
                 ticks_sent, words_checked, settings_used);
        $display("Dry %0d, leak %0d, overheat %0d results; long output holds: %0d",
                 dry_seen, leak_seen, overheat_seen, holds_done);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: files.f
design/cpc_pkg.sv
design/cpc_regs.sv
design/cpc_core.sv
design/cooling_pump_controller.sv
sim/testbench.sv
